/* rtl/pscm_pkg.sv */
// ----------------------------------------------------------------------------
// pscm_pkg
// Shared types, constants and helpers for the perspective coordinate mapper.
// ----------------------------------------------------------------------------
package pscm_pkg;

    // default frame geometry
    localparam int FRAME_WIDTH_DEF  = 80;
    localparam int FRAME_HEIGHT_DEF = 60;
    localparam int HORIZON_ROW_DEF  = 67;

    // field widths
    localparam int COL_W    = 7;
    localparam int ROW_W    = 6;
    localparam int REG_W    = 32;
    localparam int IDX_W    = 3;

    // fixed-point constants (Q16)
    localparam int GROUND_Q16    = 808613;
    localparam int INV_PITCH_Q16 = 1634314;
    localparam int ONE_Q16       = 65536;
    localparam int HALF_Q16      = 32768;
    localparam int FRAC_W        = 16;

    // datapath widths
    localparam int GX_W   = 32;              // ground coordinate, Q16
    localparam int PROD_W = 64;              // Q24 x Q16 product
    localparam int PSH_W  = PROD_W - 24;     // product floored to Q16
    localparam int OFS_W  = REG_W - 8;       // offset floored to Q16
    localparam int NUM_W  = PSH_W + 3;       // numerator
    localparam int DEN_W  = PSH_W + 1;       // denominator
    localparam int NMAG_W = NUM_W;
    localparam int DMAG_W = DEN_W;
    localparam int QBITS  = 41;              // quotient bits, one per stage
    localparam int NEXT_W = NMAG_W + FRAC_W; // scaled dividend
    localparam int Q_W    = QBITS + 1;       // signed clamped quotient
    localparam int INV_W  = 22;
    localparam int SCL_W  = Q_W + INV_W;     // quotient x inverse pitch
    localparam int S_W    = SCL_W - FRAC_W;
    localparam int V_W    = S_W - FRAC_W;

    localparam logic [QBITS-1:0] QUOT_LIMIT = QBITS'(1) << (QBITS - 1);
    localparam logic signed [INV_W-1:0] INV_PITCH_S = INV_W'(INV_PITCH_Q16);

    // register map
    typedef enum logic [IDX_W-1:0] {
        REG_COL_COEF_X  = 3'd0,
        REG_COL_COEF_Y  = 3'd1,
        REG_COL_OFFSET  = 3'd2,
        REG_COL_DENOM_Y = 3'd3,
        REG_ROW_COEF_Y  = 3'd4,
        REG_ROW_OFFSET  = 3'd5,
        REG_ROW_DENOM_Y = 3'd6
    } reg_idx_t;

    localparam logic signed [REG_W-1:0] RST_COL_COEF_X  = 32'sd186227;
    localparam logic signed [REG_W-1:0] RST_COL_COEF_Y  = 32'sd8389;
    localparam logic signed [REG_W-1:0] RST_COL_OFFSET  = 32'sd765041;
    localparam logic signed [REG_W-1:0] RST_COL_DENOM_Y = 32'sd109052;
    localparam logic signed [REG_W-1:0] RST_ROW_COEF_Y  = -32'sd73820;
    localparam logic signed [REG_W-1:0] RST_ROW_OFFSET  = 32'sd33193723;
    localparam logic signed [REG_W-1:0] RST_ROW_DENOM_Y = 32'sd58720;

    // one lane of the bit-per-stage divider
    typedef struct packed {
        logic [DMAG_W-1:0] rem;
        logic [QBITS-1:0]  quo;
        logic [QBITS-1:0]  nlow;
        logic [DMAG_W-1:0] dmag;
        logic              neg;
        logic              bad;
        logic              sat;
    } div_lane_t;

    // magnitudes, sign and saturation check ahead of the divider
    function automatic div_lane_t lane_init(logic signed [NUM_W-1:0] num,
                                            logic signed [DEN_W-1:0] den);
        logic [NMAG_W-1:0] nmag;
        logic [DMAG_W-1:0] dmag;
        logic [NEXT_W-1:0] nx;
        div_lane_t         l;
        nmag   = num[NUM_W-1] ? NMAG_W'(-num) : NMAG_W'(num);
        dmag   = den[DEN_W-1] ? DMAG_W'(-den) : DMAG_W'(den);
        nx     = {nmag, {FRAC_W{1'b0}}};
        l.rem  = DMAG_W'(nx[NEXT_W-1:QBITS]);
        l.nlow = nx[QBITS-1:0];
        l.quo  = '0;
        l.dmag = dmag;
        l.neg  = num[NUM_W-1] ^ den[DEN_W-1];
        l.bad  = (den == '0);
        // quotient would need more than QBITS bits
        l.sat  = (DMAG_W'(nx[NEXT_W-1:QBITS]) >= dmag);
        return l;
    endfunction

    // one restoring division step
    function automatic div_lane_t div_step(div_lane_t a);
        logic [DMAG_W:0] trial;
        div_lane_t       r;
        r     = a;
        trial = {a.rem, a.nlow[QBITS-1]};
        if (trial >= {1'b0, a.dmag})
        begin
            r.rem = DMAG_W'(trial - {1'b0, a.dmag});
            r.quo = {a.quo[QBITS-2:0], 1'b1};
        end
        else
        begin
            r.rem = trial[DMAG_W-1:0];
            r.quo = {a.quo[QBITS-2:0], 1'b0};
        end
        r.nlow = {a.nlow[QBITS-2:0], 1'b0};
        return r;
    endfunction

    // clamp to the quotient limit and apply the sign
    function automatic logic signed [Q_W-1:0] lane_quot(div_lane_t l);
        logic [QBITS-1:0] mag;
        mag = (l.sat || (l.quo > QUOT_LIMIT)) ? QUOT_LIMIT : l.quo;
        return l.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

endpackage

/* rtl/pscm_pix_if.sv */
// ----------------------------------------------------------------------------
// pscm_pix_if
// Valid/ready channel carrying one top-view pixel position per beat.
// ----------------------------------------------------------------------------
interface pscm_pix_if import pscm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [COL_W-1:0] out_col;
    logic [ROW_W-1:0] out_row;

    modport source (output valid, out_col, out_row, input ready);
    modport sink   (input valid, out_col, out_row, output ready);
endinterface

/* rtl/pscm_map_if.sv */
// ----------------------------------------------------------------------------
// pscm_map_if
// Valid/ready channel carrying one camera sample position per beat.
// ----------------------------------------------------------------------------
interface pscm_map_if import pscm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [COL_W-1:0] src_col;
    logic [ROW_W-1:0] src_row;
    logic             inside_res;

    modport source (output valid, src_col, src_row, inside_res, input ready);
    modport sink   (input valid, src_col, src_row, inside_res, output ready);
endinterface

/* rtl/perspective_source_coordinate_map.sv */
// ----------------------------------------------------------------------------
// perspective_source_coordinate_map
// Inverse perspective mapping: top-view pixel to camera sample position.
//
//   channel  dir  payload                          handshake
//   pix_in   in   out_col, out_row                 valid/ready
//   map_out  out  src_col, src_row, inside_res     valid/ready
//   cfg      in   cfg_index, cfg_data              cfg_we, no wait
//
// One beat per cycle while map_out is not stalled; the pipe is the 41-stage
// restoring divider (one quotient bit per stage) plus 7 stages around it.
// Each stage holds a valid bit; an empty stage fills even while the output
// is stalled, and a full pipe stalls without loss. Reset clears the valid
// bits and loads the coefficient registers with their defaults.
// ----------------------------------------------------------------------------
module perspective_source_coordinate_map import pscm_pkg::*; #(
    parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF,
    parameter int HORIZON_ROW  = HORIZON_ROW_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    pscm_pix_if.sink         pix_in,
    pscm_map_if.source       map_out,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0] cfg_data
);

    localparam int HalfW = FRAME_WIDTH / 2;
    localparam int HalfH = FRAME_HEIGHT / 2;
    localparam int NST   = QBITS + 7;
    localparam int SE    = QBITS + 4;
    localparam int SF    = QBITS + 5;
    localparam int SG    = QBITS + 6;
    localparam logic signed [S_W-1:0] ColBias = S_W'(HalfW * ONE_Q16 + HALF_Q16);
    localparam logic signed [S_W-1:0] RowBias = S_W'(HalfH * ONE_Q16 + HALF_Q16);

    // coefficient registers
    logic signed [REG_W-1:0] cx_reg, cy_reg, co_reg, dc_reg;
    logic signed [REG_W-1:0] ry_reg, ro_reg, dr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= RST_COL_COEF_X;
            cy_reg <= RST_COL_COEF_Y;
            co_reg <= RST_COL_OFFSET;
            dc_reg <= RST_COL_DENOM_Y;
            ry_reg <= RST_ROW_COEF_Y;
            ro_reg <= RST_ROW_OFFSET;
            dr_reg <= RST_ROW_DENOM_Y;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COL_COEF_X:  cx_reg <= cfg_data;
                REG_COL_COEF_Y:  cy_reg <= cfg_data;
                REG_COL_OFFSET:  co_reg <= cfg_data;
                REG_COL_DENOM_Y: dc_reg <= cfg_data;
                REG_ROW_COEF_Y:  ry_reg <= cfg_data;
                REG_ROW_OFFSET:  ro_reg <= cfg_data;
                REG_ROW_DENOM_Y: dr_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage valids and per-stage load enables
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] en;

    always_comb
    begin
        en[NST-1] = !vld_reg[NST-1] || map_out.ready;
        for (int i = NST - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= pix_in.valid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    assign pix_in.ready  = en[0];
    assign map_out.valid = vld_reg[NST-1];

    // stage A: ground coordinates
    logic signed [GX_W-1:0] gx_reg, gy_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            gx_reg <= GX_W'((int'(pix_in.out_col) - HalfW) * GROUND_Q16);
            gy_reg <= GX_W'((HORIZON_ROW - int'(pix_in.out_row)) * GROUND_Q16);
        end
    end

    // stage B: coefficient products, floored to Q16
    logic signed [PROD_W-1:0] p_cx, p_cy, p_dc, p_ry, p_dr;
    logic signed [PSH_W-1:0]  pcx_reg, pcy_reg, pdc_reg, pry_reg, pdr_reg;

    assign p_cx = PROD_W'(cx_reg) * PROD_W'(gx_reg);
    assign p_cy = PROD_W'(cy_reg) * PROD_W'(gy_reg);
    assign p_dc = PROD_W'(dc_reg) * PROD_W'(gy_reg);
    assign p_ry = PROD_W'(ry_reg) * PROD_W'(gy_reg);
    assign p_dr = PROD_W'(dr_reg) * PROD_W'(gy_reg);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            pcx_reg <= p_cx[PROD_W-1:24];
            pcy_reg <= p_cy[PROD_W-1:24];
            pdc_reg <= p_dc[PROD_W-1:24];
            pry_reg <= p_ry[PROD_W-1:24];
            pdr_reg <= p_dr[PROD_W-1:24];
        end
    end

    // stage C: numerators and denominators
    logic signed [OFS_W-1:0] co_sh, ro_sh;
    logic signed [NUM_W-1:0] num_c_next, num_r_next, num_c_reg, num_r_reg;
    logic signed [DEN_W-1:0] den_c_next, den_r_next, den_c_reg, den_r_reg;
    logic signed [DEN_W-1:0] one_den;

    assign co_sh      = $signed(co_reg[REG_W-1:8]);
    assign ro_sh      = $signed(ro_reg[REG_W-1:8]);
    assign one_den    = DEN_W'(ONE_Q16);
    assign num_c_next = NUM_W'(pcx_reg) + NUM_W'(pcy_reg) + NUM_W'(co_sh);
    assign num_r_next = NUM_W'(pry_reg) + NUM_W'(ro_sh);
    assign den_c_next = DEN_W'(pdc_reg) + one_den;
    assign den_r_next = DEN_W'(pdr_reg) + one_den;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            num_c_reg <= num_c_next;
            num_r_reg <= num_r_next;
            den_c_reg <= den_c_next;
            den_r_reg <= den_r_next;
        end
    end

    // stage D: divider setup
    div_lane_t ld_c_reg, ld_r_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            ld_c_reg <= lane_init(num_c_reg, den_c_reg);
            ld_r_reg <= lane_init(num_r_reg, den_r_reg);
        end
    end

    // divider: one quotient bit per stage
    div_lane_t dv_c_reg [QBITS];
    div_lane_t dv_r_reg [QBITS];

    for (genvar k = 0; k < QBITS; k++)
    begin : g_div
        div_lane_t src_c, src_r;
        if (k == 0)
        begin : g_first
            assign src_c = ld_c_reg;
            assign src_r = ld_r_reg;
        end
        else
        begin : g_rest
            assign src_c = dv_c_reg[k-1];
            assign src_r = dv_r_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (en[4+k])
            begin
                dv_c_reg[k] <= div_step(src_c);
                dv_r_reg[k] <= div_step(src_r);
            end
        end
    end

    // stage E: clamped signed quotients
    logic signed [Q_W-1:0] q_c_reg, q_r_reg;
    logic                  bad_c_e_reg, bad_r_e_reg;

    always_ff @(posedge clk)
    begin
        if (en[SE])
        begin
            q_c_reg     <= lane_quot(dv_c_reg[QBITS-1]);
            q_r_reg     <= lane_quot(dv_r_reg[QBITS-1]);
            bad_c_e_reg <= dv_c_reg[QBITS-1].bad;
            bad_r_e_reg <= dv_r_reg[QBITS-1].bad;
        end
    end

    // stage F: scale by inverse pixel pitch
    logic signed [SCL_W-1:0] sc_c, sc_r;
    logic signed [S_W-1:0]   s_c_reg, s_r_reg;
    logic                    bad_c_f_reg, bad_r_f_reg;

    assign sc_c = SCL_W'(q_c_reg) * SCL_W'(INV_PITCH_S);
    assign sc_r = SCL_W'(q_r_reg) * SCL_W'(INV_PITCH_S);

    always_ff @(posedge clk)
    begin
        if (en[SF])
        begin
            s_c_reg     <= sc_c[SCL_W-1:FRAC_W];
            s_r_reg     <= sc_r[SCL_W-1:FRAC_W];
            bad_c_f_reg <= bad_c_e_reg;
            bad_r_f_reg <= bad_r_e_reg;
        end
    end

    // stage G: center, round half up, range check
    logic signed [S_W-1:0] t_c, t_r;
    logic [V_W-1:0]        v_c, v_r;
    logic                  ok_c, ok_r, ok;
    logic [COL_W-1:0]      src_col_reg;
    logic [ROW_W-1:0]      src_row_reg;
    logic                  inside_reg;

    assign t_c  = s_c_reg + ColBias;
    assign t_r  = s_r_reg + RowBias;
    assign v_c  = t_c[S_W-1:FRAC_W];
    assign v_r  = t_r[S_W-1:FRAC_W];
    assign ok_c = !bad_c_f_reg && !t_c[S_W-1] && (v_c < V_W'(FRAME_WIDTH));
    assign ok_r = !bad_r_f_reg && !t_r[S_W-1] && (v_r < V_W'(FRAME_HEIGHT));
    assign ok   = ok_c && ok_r;

    always_ff @(posedge clk)
    begin
        if (en[SG])
        begin
            src_col_reg <= ok ? v_c[COL_W-1:0] : '0;
            src_row_reg <= ok ? v_r[ROW_W-1:0] : '0;
            inside_reg  <= ok;
        end
    end

    assign map_out.src_col    = src_col_reg;
    assign map_out.src_row    = src_row_reg;
    assign map_out.inside_res = inside_reg;

endmodule

/* rtl/pscm_checker.sv */
// ----------------------------------------------------------------------------
// pscm_checker
// Port-level assertions for the perspective coordinate mapper.
// ----------------------------------------------------------------------------
module pscm_checker import pscm_pkg::*; #(
    parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
    input logic             clk,
    input logic             rst_n,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [COL_W-1:0] src_col,
    input logic [ROW_W-1:0] src_row,
    input logic             inside_res
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(src_col)
            && $stable(src_row) && $stable(inside_res))
        else $error("stalled result beat changed");

    // outside points report zero coordinates
    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !inside_res |-> src_col == '0 && src_row == '0)
        else $error("outside point with nonzero coordinates");

    // inside points lie in the frame
    a_inside_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && inside_res |-> int'(src_col) < FRAME_WIDTH
            && int'(src_row) < FRAME_HEIGHT)
        else $error("inside point beyond frame");

    // input only backs up behind a waiting result
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled with no stalled result");

    // nothing emerges while reset is asserted
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result beat during reset");

endmodule

bind perspective_source_coordinate_map pscm_checker #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
) u_pscm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (pix_in.ready),
    .out_valid  (map_out.valid),
    .out_ready  (map_out.ready),
    .src_col    (map_out.src_col),
    .src_row    (map_out.src_row),
    .inside_res (map_out.inside_res)
);
